>>> rtl/core/lpe_pkg.sv
// ----------------------------------------------------------------------------
// LSB payload extractor package
// Shared types and constants for the front end, the group queue and the
// header/payload back end.
// ----------------------------------------------------------------------------
`default_nettype none

package lpe_pkg;

    localparam int unsigned LANES       = 3;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned PHASE_W     = 2;
    localparam int unsigned HCOUNT_W    = 5;
    localparam int unsigned OUT_LEN_W   = 32;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PHASE_W-1:0]  PHASE_FIRST = 2'd0;
    localparam logic [PHASE_W-1:0]  PHASE_LAST  = 2'd3;
    localparam logic [1:0]          BYTE_LAST   = 2'd2;
    localparam logic [HCOUNT_W-1:0] HCOUNT_MAX  = 5'd31;

    // Parser modes.
    localparam logic [1:0] MODE_HEADER  = 2'd0;
    localparam logic [1:0] MODE_PAYLOAD = 2'd1;
    localparam logic [1:0] MODE_DONE    = 2'd2;
    localparam logic [1:0] MODE_HALT    = 2'd3;

    localparam logic [BYTE_W-1:0] CHAR_TEXT = 8'h3C;
    localparam logic [BYTE_W-1:0] CHAR_FILE = 8'h3E;
    localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;

    typedef struct packed {
        logic                               restart;
        logic [LANES-1:0][BYTE_W-1:0]       bytes;
    } group_t;

    typedef struct packed {
        logic [BYTE_W-1:0]    payload_byte;
        logic                 byte_valid;
        logic                 is_file;
        logic [OUT_LEN_W-1:0] payload_length;
        logic                 end_of_payload;
        logic                 header_error;
        logic                 last;
    } result_t;

    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

>>> rtl/core/lpe_front.sv
// ----------------------------------------------------------------------------
// LSB payload extractor front end
// Accepts pixels, gathers the two low bits of each component over a group
// of four pixels and pushes the three finished bytes into the group queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lpe_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        start_of_image,
    input  wire logic [lpe_pkg::BYTE_W-1:0]  comp_red,
    input  wire logic [lpe_pkg::BYTE_W-1:0]  comp_green,
    input  wire logic [lpe_pkg::BYTE_W-1:0]  comp_blue,
    input  wire lpe_pkg::queue_status_t      q_status,
    output logic                             q_push,
    output lpe_pkg::group_t                  q_wdata
);

    logic [lpe_pkg::PHASE_W-1:0]                     phase_reg;
    logic [lpe_pkg::PHASE_W-1:0]                     phase_next;
    logic                                            restart_reg;
    logic                                            restart_next;
    logic [lpe_pkg::LANES-1:0][lpe_pkg::BYTE_W-1:0]  accum_reg;
    logic [lpe_pkg::LANES-1:0][lpe_pkg::BYTE_W-1:0]  accum_next;
    logic [lpe_pkg::LANES-1:0][1:0]                  low_bits;
    logic [lpe_pkg::PHASE_W-1:0]                     eff_phase;
    logic                                            accept;

    // Only the fourth pixel of a group writes the queue, so stall only then.
    assign in_stall = (phase_reg == lpe_pkg::PHASE_LAST) && q_status.full;
    assign accept   = in_valid && !in_stall;

    // A start of image makes this pixel the first of a new group.
    assign eff_phase = start_of_image ? lpe_pkg::PHASE_FIRST : phase_reg;

    assign low_bits[0] = comp_red[1:0];
    assign low_bits[1] = comp_green[1:0];
    assign low_bits[2] = comp_blue[1:0];

    always_comb
    begin
        for (int j = 0; j < lpe_pkg::LANES; j++)
        begin
            accum_next[j] = (eff_phase == lpe_pkg::PHASE_FIRST) ? '0 : accum_reg[j];
            accum_next[j][2*eff_phase +: 2] = low_bits[j];
        end
        restart_next = (eff_phase == lpe_pkg::PHASE_FIRST) ? start_of_image : restart_reg;
        phase_next   = eff_phase + lpe_pkg::PHASE_W'(1);
    end

    assign q_push          = accept && (eff_phase == lpe_pkg::PHASE_LAST);
    assign q_wdata.restart = restart_next;
    assign q_wdata.bytes   = accum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= lpe_pkg::PHASE_FIRST;
            restart_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            restart_reg <= restart_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            accum_reg <= accum_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lpe_queue.sv
// ----------------------------------------------------------------------------
// LSB payload extractor group queue
// Short first-in first-out queue of byte groups between the front end and
// the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lpe_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire lpe_pkg::queue_ctrl_t   ctrl,
    input  wire lpe_pkg::group_t        wdata,
    output lpe_pkg::group_t             rdata,
    output lpe_pkg::queue_status_t      status
);

    lpe_pkg::group_t                   entry_reg [lpe_pkg::QUEUE_DEPTH];
    logic [lpe_pkg::QUEUE_AW-1:0]      wr_ptr_reg;
    logic [lpe_pkg::QUEUE_AW-1:0]      rd_ptr_reg;
    logic [lpe_pkg::QUEUE_CW-1:0]      count_reg;
    logic [lpe_pkg::QUEUE_AW-1:0]      wr_ptr_next;
    logic [lpe_pkg::QUEUE_AW-1:0]      rd_ptr_next;
    logic [lpe_pkg::QUEUE_CW-1:0]      count_next;
    logic                              do_push;
    logic                              do_pop;

    assign status.full  = (count_reg == lpe_pkg::QUEUE_CW'(lpe_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = ctrl.push && !status.full;
    assign do_pop       = ctrl.pop && !status.empty;
    assign rdata        = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == lpe_pkg::QUEUE_AW'(lpe_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + lpe_pkg::QUEUE_AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == lpe_pkg::QUEUE_AW'(lpe_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + lpe_pkg::QUEUE_AW'(1);
        end
        count_next = count_reg + lpe_pkg::QUEUE_CW'(do_push) - lpe_pkg::QUEUE_CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lpe_back.sv
// ----------------------------------------------------------------------------
// LSB payload extractor back end
// Walks each queued group's three bytes, one per cycle unless stalled, parses
// the decimal length header and emits payload bytes into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpe_back #(
    parameter int HEADER_LIMIT = 16,
    parameter int LENGTH_BITS  = 32
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire lpe_pkg::group_t         q_rdata,
    input  wire lpe_pkg::queue_status_t  q_status,
    output logic                         q_pop,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output lpe_pkg::result_t             result
);

    localparam int PROD_W = LENGTH_BITS + 4;
    localparam int EXT_W  = (LENGTH_BITS > lpe_pkg::OUT_LEN_W) ? LENGTH_BITS
                                                                : lpe_pkg::OUT_LEN_W;

    logic [1:0]                      idx_reg;
    logic [1:0]                      mode_reg;
    logic [LENGTH_BITS-1:0]          length_reg;
    logic [lpe_pkg::HCOUNT_W-1:0]    hcount_reg;
    logic [LENGTH_BITS-1:0]          emitted_reg;
    logic                            file_reg;
    logic                            out_valid_reg;
    lpe_pkg::result_t                result_reg;

    logic [1:0]                      cur_mode;
    logic [LENGTH_BITS-1:0]          cur_length;
    logic [lpe_pkg::HCOUNT_W-1:0]    cur_hcount;
    logic [LENGTH_BITS-1:0]          cur_emitted;
    logic                            cur_file;

    logic [1:0]                      mode_next;
    logic [LENGTH_BITS-1:0]          length_next;
    logic [lpe_pkg::HCOUNT_W-1:0]    hcount_next;
    logic [LENGTH_BITS-1:0]          emitted_next;
    logic                            file_next;
    logic [1:0]                      idx_next;

    logic [lpe_pkg::BYTE_W-1:0]      cur_byte;
    logic [lpe_pkg::BYTE_W-1:0]      digit_full;
    logic [3:0]                      digit;
    logic                            is_digit;
    logic                            is_term;
    logic [PROD_W-1:0]               prod;
    logic                            overflow;
    logic [EXT_W-1:0]                len_ext;
    logic                            out_free;
    logic                            step;
    logic                            restart_now;

    logic                            produce;
    logic                            res_valid;
    logic                            res_end;
    logic                            res_err;
    lpe_pkg::result_t                result_next;

    assign out_free    = !out_valid_reg || !out_stall;
    assign step        = !q_status.empty && out_free;
    assign q_pop       = step && (idx_reg == lpe_pkg::BYTE_LAST);
    assign restart_now = q_rdata.restart && (idx_reg == 2'd0);
    assign cur_byte    = q_rdata.bytes[idx_reg];

    // The first byte of a group that began an image sees the state cleared.
    assign cur_mode    = restart_now ? lpe_pkg::MODE_HEADER : mode_reg;
    assign cur_length  = restart_now ? '0 : length_reg;
    assign cur_hcount  = restart_now ? '0 : hcount_reg;
    assign cur_emitted = restart_now ? '0 : emitted_reg;
    assign cur_file    = restart_now ? 1'b0 : file_reg;

    assign is_term    = (cur_byte == lpe_pkg::CHAR_TEXT) || (cur_byte == lpe_pkg::CHAR_FILE);
    assign is_digit   = (cur_byte >= lpe_pkg::CHAR_ZERO) && (cur_byte <= lpe_pkg::CHAR_NINE);
    assign digit_full = cur_byte - lpe_pkg::CHAR_ZERO;
    assign digit      = digit_full[3:0];

    // length * 10 + digit, with four spare bits to spot an overflow.
    assign prod = ({4'b0, cur_length} << 3) + ({4'b0, cur_length} << 1)
                  + PROD_W'(digit);
    assign overflow = |prod[PROD_W-1:LENGTH_BITS];

    always_comb
    begin
        mode_next    = cur_mode;
        length_next  = cur_length;
        hcount_next  = cur_hcount;
        emitted_next = cur_emitted;
        file_next    = cur_file;
        produce      = 1'b0;
        res_valid    = 1'b0;
        res_end      = 1'b0;
        res_err      = 1'b0;

        unique case (cur_mode)
            lpe_pkg::MODE_HEADER:
            begin
                if (cur_hcount != lpe_pkg::HCOUNT_MAX)
                begin
                    hcount_next = cur_hcount + lpe_pkg::HCOUNT_W'(1);
                end
                if (is_term)
                begin
                    file_next = (cur_byte == lpe_pkg::CHAR_FILE);
                    mode_next = lpe_pkg::MODE_PAYLOAD;
                    if (cur_length == '0)
                    begin
                        produce   = 1'b1;
                        res_end   = 1'b1;
                        mode_next = lpe_pkg::MODE_DONE;
                    end
                end
                else if (is_digit && !overflow)
                begin
                    length_next = prod[LENGTH_BITS-1:0];
                end
                else
                begin
                    produce   = 1'b1;
                    res_err   = 1'b1;
                    mode_next = lpe_pkg::MODE_HALT;
                end
                // Overlong header check once the whole group is consumed.
                if ((idx_reg == lpe_pkg::BYTE_LAST) && (mode_next == lpe_pkg::MODE_HEADER)
                    && (hcount_next >= lpe_pkg::HCOUNT_W'(HEADER_LIMIT)))
                begin
                    produce   = 1'b1;
                    res_err   = 1'b1;
                    mode_next = lpe_pkg::MODE_HALT;
                end
            end
            lpe_pkg::MODE_PAYLOAD:
            begin
                emitted_next = cur_emitted + LENGTH_BITS'(1);
                produce      = 1'b1;
                res_valid    = 1'b1;
                if (emitted_next >= cur_length)
                begin
                    res_end   = 1'b1;
                    mode_next = lpe_pkg::MODE_DONE;
                end
            end
            lpe_pkg::MODE_DONE,
            lpe_pkg::MODE_HALT:
            begin
                produce = 1'b0;
            end
            default:
            begin
                produce = 1'b0;
            end
        endcase
    end

    assign len_ext = EXT_W'(length_next);

    always_comb
    begin
        result_next.payload_byte   = res_valid ? cur_byte : '0;
        result_next.byte_valid     = res_valid;
        result_next.is_file        = res_err ? 1'b0 : file_next;
        result_next.payload_length = res_err ? '0 : len_ext[lpe_pkg::OUT_LEN_W-1:0];
        result_next.end_of_payload = res_end;
        result_next.header_error   = res_err;
        // No later byte of the group can give a result once the parser stops.
        result_next.last           = (idx_reg == lpe_pkg::BYTE_LAST)
                                     || (mode_next == lpe_pkg::MODE_DONE)
                                     || (mode_next == lpe_pkg::MODE_HALT);
    end

    assign idx_next = (idx_reg == lpe_pkg::BYTE_LAST) ? 2'd0 : idx_reg + 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            mode_reg      <= lpe_pkg::MODE_HEADER;
            length_reg    <= '0;
            hcount_reg    <= '0;
            emitted_reg   <= '0;
            file_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                idx_reg     <= idx_next;
                mode_reg    <= mode_next;
                length_reg  <= length_next;
                hcount_reg  <= hcount_next;
                emitted_reg <= emitted_next;
                file_reg    <= file_next;
            end
            if (out_free)
            begin
                out_valid_reg <= step && produce;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && step && produce)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

>>> rtl/core/lsb_payload_extractor_top.sv
// Path: an accepted fourth pixel writes its group into the queue; the back end then
// takes bytes 0 to 2 in order and registers each result in the output register.
// Throughput: one pixel per cycle while in_stall is low; the back end takes the
// three bytes of each group in turn, and a two-entry group queue absorbs jitter.
// Reset: asynchronous and active low; it empties the queue and output register
// and puts the parser in header mode.
// ----------------------------------------------------------------------------
// LSB payload extractor top level
// Recovers a length-prefixed payload hidden in the two low bits of the color
// components of an RGB pixel stream.
// ----------------------------------------------------------------------------
`default_nettype none

module lsb_payload_extractor_top #(
    parameter int HEADER_LIMIT = 16,
    parameter int LENGTH_BITS  = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           start_of_image,
    input  wire logic [lpe_pkg::BYTE_W-1:0]     comp_red,
    input  wire logic [lpe_pkg::BYTE_W-1:0]     comp_green,
    input  wire logic [lpe_pkg::BYTE_W-1:0]     comp_blue,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [lpe_pkg::BYTE_W-1:0]          payload_byte,
    output logic                                byte_valid,
    output logic                                is_file,
    output logic [lpe_pkg::OUT_LEN_W-1:0]       payload_length,
    output logic                                end_of_payload,
    output logic                                header_error,
    output logic                                last
);

    lpe_pkg::queue_ctrl_t    q_ctrl;
    lpe_pkg::queue_status_t  q_status;
    lpe_pkg::group_t         q_wdata;
    lpe_pkg::group_t         q_rdata;
    lpe_pkg::result_t        result;
    logic                    q_push;
    logic                    q_pop;

    lpe_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .start_of_image (start_of_image),
        .comp_red       (comp_red),
        .comp_green     (comp_green),
        .comp_blue      (comp_blue),
        .q_status       (q_status),
        .q_push         (q_push),
        .q_wdata        (q_wdata)
    );

    assign q_ctrl.push = q_push;
    assign q_ctrl.pop  = q_pop;

    lpe_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (q_ctrl),
        .wdata  (q_wdata),
        .rdata  (q_rdata),
        .status (q_status)
    );

    lpe_back #(
        .HEADER_LIMIT (HEADER_LIMIT),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_rdata   (q_rdata),
        .q_status  (q_status),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    assign payload_byte   = result.payload_byte;
    assign byte_valid     = result.byte_valid;
    assign is_file        = result.is_file;
    assign payload_length = result.payload_length;
    assign end_of_payload = result.end_of_payload;
    assign header_error   = result.header_error;
    assign last           = result.last;

endmodule

`default_nettype wire

>>> tb/sv/lsb_payload_extractor_top_test.sv
// ----------------------------------------------------------------------------
// LSB payload extractor testbench
// Streams pixels that hide length-prefixed messages in the two low bits of
// each color component, and checks every result of the block against a
// predictor. The messages are well-formed, truncated, too long, too large or
// corrupt, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsb_payload_extractor_top_test;

    localparam int          HEADER_LIMIT = 16;
    localparam int          LENGTH_BITS  = 32;
    localparam logic [63:0] LENGTH_MAX   = (64'd1 << LENGTH_BITS) - 64'd1;
    localparam int          PIXEL_TARGET = 470;
    localparam int          CALM_PIXELS  = 50;
    localparam int          SETTLE       = 16;
    localparam int          CYCLE_LIMIT  = 200000;

    class payload_tracker;
        lpe_pkg::result_t due_results [$];
        int unsigned      errors;
        int unsigned      seen_count;

        logic [1:0]  phase;
        logic [7:0]  acc [3];
        logic [1:0]  mode;
        logic [63:0] length_val;
        logic [4:0]  hdr_count;
        logic [63:0] emitted;
        logic        file_kind;

        function new();
            errors     = 0;
            seen_count = 0;
            restart();
        endfunction

        function void restart();
            phase      = lpe_pkg::PHASE_FIRST;
            acc[0]     = '0;
            acc[1]     = '0;
            acc[2]     = '0;
            mode       = lpe_pkg::MODE_HEADER;
            length_val = '0;
            hdr_count  = '0;
            emitted    = '0;
            file_kind  = 1'b0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function lpe_pkg::result_t make_result(logic [7:0] data, logic valid, logic endp,
                                               logic err);
            lpe_pkg::result_t r;
            r.payload_byte   = data;
            r.byte_valid     = valid;
            r.is_file        = err ? 1'b0 : file_kind;
            r.payload_length = err ? '0 : length_val[31:0];
            r.end_of_payload = endp;
            r.header_error   = err;
            r.last           = 1'b0;
            return r;
        endfunction

        // Works out what one accepted pixel request makes the block emit.
        function void decode_pixel(logic sop, logic [7:0] red, logic [7:0] green,
                                   logic [7:0] blue);
            logic [7:0]       low_src [3];
            lpe_pkg::result_t batch [$];
            lpe_pkg::result_t tail;
            logic [7:0]       cur;
            logic [63:0]      digit_val;
            int               j;
            if (sop)
                restart();
            low_src[0] = red;
            low_src[1] = green;
            low_src[2] = blue;
            if (phase == lpe_pkg::PHASE_FIRST)
            begin
                for (j = 0; j < 3; j++)
                    acc[j] = '0;
            end
            for (j = 0; j < 3; j++)
                acc[j][2*phase +: 2] = low_src[j][1:0];
            if (phase != lpe_pkg::PHASE_LAST)
            begin
                phase = phase + 2'd1;
                return;
            end
            phase = lpe_pkg::PHASE_FIRST;
            for (j = 0; j < 3; j++)
            begin
                cur       = acc[j];
                digit_val = 64'(cur) - 64'(lpe_pkg::CHAR_ZERO);
                if (mode == lpe_pkg::MODE_HEADER)
                begin
                    if (hdr_count != lpe_pkg::HCOUNT_MAX)
                        hdr_count = hdr_count + 5'd1;
                    if (cur == lpe_pkg::CHAR_TEXT || cur == lpe_pkg::CHAR_FILE)
                    begin
                        file_kind = (cur == lpe_pkg::CHAR_FILE);
                        mode      = lpe_pkg::MODE_PAYLOAD;
                        if (length_val == 0)
                        begin
                            batch.push_back(make_result(8'd0, 1'b0, 1'b1, 1'b0));
                            mode = lpe_pkg::MODE_DONE;
                        end
                    end
                    else if (cur >= lpe_pkg::CHAR_ZERO && cur <= lpe_pkg::CHAR_NINE &&
                             length_val <= (LENGTH_MAX - digit_val) / 64'd10)
                    begin
                        length_val = length_val * 64'd10 + digit_val;
                    end
                    else
                    begin
                        mode = lpe_pkg::MODE_HALT;
                        batch.push_back(make_result(8'd0, 1'b0, 1'b0, 1'b1));
                    end
                end
                else if (mode == lpe_pkg::MODE_PAYLOAD)
                begin
                    emitted = emitted + 64'd1;
                    batch.push_back(make_result(cur, 1'b1, emitted >= length_val, 1'b0));
                    if (emitted >= length_val)
                        mode = lpe_pkg::MODE_DONE;
                end
            end
            // A header that is still open after a whole group may have run too long.
            if (mode == lpe_pkg::MODE_HEADER && hdr_count >= HEADER_LIMIT)
            begin
                mode = lpe_pkg::MODE_HALT;
                batch.push_back(make_result(8'd0, 1'b0, 1'b0, 1'b1));
            end
            if (batch.size() > 0)
            begin
                tail      = batch.pop_back();
                tail.last = 1'b1;
                batch.push_back(tail);
            end
            foreach (batch[k])
                due_results.push_back(batch[k]);
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch at result %0d: %s", seen_count, msg);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s is %0h, expected %0h", name, got, want));
        endtask

        task check_result(lpe_pkg::result_t got);
            lpe_pkg::result_t want;
            if (due_results.size() == 0)
            begin
                report("result arrived with nothing expected");
            end
            else
            begin
                want = due_results.pop_front();
                compare_field("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
                compare_field("byte_valid", 32'(got.byte_valid), 32'(want.byte_valid));
                compare_field("is_file", 32'(got.is_file), 32'(want.is_file));
                compare_field("payload_length", got.payload_length, want.payload_length);
                compare_field("end_of_payload", 32'(got.end_of_payload),
                              32'(want.end_of_payload));
                compare_field("header_error", 32'(got.header_error), 32'(want.header_error));
                compare_field("last", 32'(got.last), 32'(want.last));
            end
            seen_count++;
        endtask
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic                          start_of_image;
    logic [lpe_pkg::BYTE_W-1:0]    comp_red;
    logic [lpe_pkg::BYTE_W-1:0]    comp_green;
    logic [lpe_pkg::BYTE_W-1:0]    comp_blue;
    logic                          out_valid;
    logic                          out_stall;
    logic [lpe_pkg::BYTE_W-1:0]    payload_byte;
    logic                          byte_valid;
    logic                          is_file;
    logic [lpe_pkg::OUT_LEN_W-1:0] payload_length;
    logic                          end_of_payload;
    logic                          header_error;
    logic                          last;

    payload_tracker   book;
    lpe_pkg::result_t observed;
    logic [7:0]       frame_q [$];
    int               sent_pixels;
    int               cycle_count;
    int               upper_fill;
    bit               idle_on;
    bit               stall_on;
    bit               calm;

    lsb_payload_extractor_top #(
        .HEADER_LIMIT (HEADER_LIMIT),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .start_of_image (start_of_image),
        .comp_red       (comp_red),
        .comp_green     (comp_green),
        .comp_blue      (comp_blue),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .payload_byte   (payload_byte),
        .byte_valid     (byte_valid),
        .is_file        (is_file),
        .payload_length (payload_length),
        .end_of_payload (end_of_payload),
        .header_error   (header_error),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Both channels are sampled at the edge that completes a request.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                book.decode_pixel(start_of_image, comp_red, comp_green, comp_blue);
            if (out_valid && !out_stall)
            begin
                observed.payload_byte   = payload_byte;
                observed.byte_valid     = byte_valid;
                observed.is_file        = is_file;
                observed.payload_length = payload_length;
                observed.end_of_payload = end_of_payload;
                observed.header_error   = header_error;
                observed.last           = last;
                book.check_result(observed);
            end
        end
    end

    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_on && !calm && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [5:0] upper_bits();
        case (upper_fill)
            1: return 6'h00;
            2: return 6'h3F;
            default: return 6'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while ((b >= lpe_pkg::CHAR_ZERO && b <= lpe_pkg::CHAR_NINE) ||
               b == lpe_pkg::CHAR_TEXT || b == lpe_pkg::CHAR_FILE);
        return b;
    endfunction

    task automatic send_pixel(input logic sop, input logic [7:0] red,
                              input logic [7:0] green, input logic [7:0] blue);
        if (idle_on && !calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        start_of_image <= sop;
        comp_red       <= red;
        comp_green     <= green;
        comp_blue      <= blue;
        do
            @(posedge clk);
        while (in_stall);
        sent_pixels++;
    endtask

    // Hides the queued bytes in groups of four pixels; cut stops after that
    // many pixels so that a message can end in the middle of a group.
    task automatic send_frame(input bit sop_first, input int cut);
        logic [7:0] comp [3];
        int         g;
        int         p;
        int         j;
        int         sent;
        while (frame_q.size() % 3 != 0)
            frame_q.push_back(8'($urandom));
        sent = 0;
        for (g = 0; g < frame_q.size() / 3; g++)
        begin
            for (p = 0; p < 4; p++)
            begin
                if (cut < 0 || sent < cut)
                begin
                    for (j = 0; j < 3; j++)
                        comp[j] = {upper_bits(), frame_q[3*g+j][2*p +: 2]};
                    send_pixel(sop_first && g == 0 && p == 0, comp[0], comp[1], comp[2]);
                    sent++;
                end
            end
        end
        frame_q.delete();
    endtask

    task automatic push_decimal(input logic [63:0] value, input int zeros);
        logic [7:0] digits [$];
        int         k;
        for (k = 0; k < zeros; k++)
            frame_q.push_back(lpe_pkg::CHAR_ZERO);
        do
        begin
            digits.push_front(lpe_pkg::CHAR_ZERO + 8'(value % 64'd10));
            value = value / 64'd10;
        end
        while (value != 0);
        for (k = 0; k < digits.size(); k++)
            frame_q.push_back(digits[k]);
    endtask

    task automatic push_random(input int count);
        int k;
        for (k = 0; k < count; k++)
            frame_q.push_back(8'($urandom));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic run_directed();
        // Zero length right after reset, with no image start, and all-zero upper bits.
        upper_fill = 1;
        push_decimal(64'd0, 0);
        frame_q.push_back(lpe_pkg::CHAR_TEXT);
        frame_q.push_back(8'h00);
        send_frame(1'b0, -1);

        // Two-byte file payload; the rest of the second group is ignored.
        upper_fill = 2;
        push_decimal(64'd2, 0);
        frame_q.push_back(lpe_pkg::CHAR_FILE);
        frame_q.push_back(8'hFF);
        frame_q.push_back(8'h00);
        frame_q.push_back(8'h5A);
        frame_q.push_back(8'hA5);
        send_frame(1'b1, -1);

        // A corrupt header byte halts the block.
        upper_fill = 0;
        frame_q.push_back(8'h78);
        push_decimal(64'd12, 0);
        send_frame(1'b1, -1);

        // An unfinished group is dropped by the next image start.
        push_decimal(64'd7, 0);
        frame_q.push_back(lpe_pkg::CHAR_TEXT);
        send_frame(1'b1, 2);

        // One past the largest length.
        push_decimal(64'd4294967296, 0);
        frame_q.push_back(lpe_pkg::CHAR_TEXT);
        send_frame(1'b1, -1);

        // A header that never ends.
        push_decimal(64'd0, 17);
        send_frame(1'b1, -1);
    endtask

    task automatic run_random();
        int          kind;
        int          len;
        int          n_pix;
        int          cut;
        int          k;
        bit          drained_mid;
        logic [63:0] value;
        drained_mid = 1'b0;
        while (sent_pixels < PIXEL_TARGET)
        begin
            calm       = (sent_pixels >= PIXEL_TARGET - CALM_PIXELS);
            idle_on    = ($urandom_range(0, 3) != 0);
            stall_on   = ($urandom_range(0, 3) != 0);
            upper_fill = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
            if (!drained_mid && sent_pixels >= PIXEL_TARGET / 2)
            begin
                wait_drained();
                drained_mid = 1'b1;
            end
            kind = $urandom_range(0, 99);
            cut  = -1;
            if (kind < 55)
            begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 9);
                push_decimal(64'(len), ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
                frame_q.push_back($urandom_range(0, 1) ? lpe_pkg::CHAR_FILE
                                                       : lpe_pkg::CHAR_TEXT);
                push_random(len + $urandom_range(0, 5));
                n_pix = (frame_q.size() + 2) / 3 * 4;
                if ($urandom_range(0, 6) == 0)
                    cut = $urandom_range(0, n_pix - 1);
                send_frame(1'b1, cut);
            end
            else if (kind < 65)
            begin
                value = $urandom_range(0, 1) ? LENGTH_MAX : 64'($urandom);
                push_decimal(value, 0);
                frame_q.push_back($urandom_range(0, 1) ? lpe_pkg::CHAR_FILE
                                                       : lpe_pkg::CHAR_TEXT);
                push_random($urandom_range(3, 9));
                send_frame(1'b1, -1);
            end
            else if (kind < 73)
            begin
                value = $urandom_range(0, 2) == 0 ? LENGTH_MAX + 64'd1
                                                  : {27'd0, 5'($urandom_range(1, 22)), $urandom};
                push_decimal(value, $urandom_range(0, 1));
                frame_q.push_back(lpe_pkg::CHAR_TEXT);
                push_random($urandom_range(0, 3));
                send_frame(1'b1, -1);
            end
            else if (kind < 83)
            begin
                len = $urandom_range(0, 4);
                for (k = 0; k < len; k++)
                    frame_q.push_back(lpe_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
                frame_q.push_back(junk_byte());
                push_random($urandom_range(0, 6));
                send_frame(1'b1, -1);
            end
            else if (kind < 90)
            begin
                // Headers close to the length limit, some of them just short of it.
                push_decimal(64'($urandom_range(1, 99)), $urandom_range(11, 19));
                frame_q.push_back($urandom_range(0, 1) ? lpe_pkg::CHAR_FILE
                                                       : lpe_pkg::CHAR_TEXT);
                push_random(4);
                send_frame(1'b1, -1);
            end
            else
            begin
                len = $urandom_range(1, 12);
                for (k = 0; k < len; k++)
                    send_pixel($urandom_range(0, 3) == 0, 8'($urandom), 8'($urandom),
                               8'($urandom));
            end
        end
    endtask

    initial
    begin
        book           = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        start_of_image = 1'b0;
        comp_red       = '0;
        comp_green     = '0;
        comp_blue      = '0;
        sent_pixels    = 0;
        cycle_count    = 0;
        upper_fill     = 0;
        idle_on        = 1'b1;
        stall_on       = 1'b1;
        calm           = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        wait_drained();
        run_random();
        wait_drained();
        if (book.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
